FILE: rtl/cfsw_pkg.sv
// ----------------------------------------------------------------------------
// cfsw_pkg
// Types and constants shared by the color frame stop-and-wait sender.
// ----------------------------------------------------------------------------
package cfsw_pkg;

  localparam int unsigned LED_TOTAL   = 8;
  localparam int unsigned CHANNELS    = 3;
  localparam int unsigned STORE_DEPTH = LED_TOTAL * CHANNELS;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned NEXT_LED_W  = $clog2(LED_TOTAL + 1);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_START = 2'd1,
    MODE_REPLY = 2'd2
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAK_CODE   = 2'd2;

  localparam logic [7:0] START_CODE_RST = 8'd0;
  localparam logic [7:0] ACK_CODE_RST   = 8'd1;
  localparam logic [7:0] NAK_CODE_RST   = 8'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] led_index;
    logic [1:0] channel;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_done;
  } out_item_t;

endpackage

FILE: rtl/cfsw_core.sv
// ----------------------------------------------------------------------------
// cfsw_core
// Color store, frame position and reply decoding; one transaction per cycle while item_accept_i is high.
// ----------------------------------------------------------------------------
module cfsw_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cfsw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cfsw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              item_accept_i,
  input  cfsw_pkg::in_item_t                item_i,
  output logic                              res_valid_o,
  output cfsw_pkg::out_item_t               res_o
);

  localparam int unsigned POS_W = cfsw_pkg::NEXT_LED_W + 2;

  logic [7:0] start_code_q, ack_code_q, nak_code_q;
  logic [7:0] store_q [cfsw_pkg::STORE_DEPTH];
  logic       waiting_q, waiting_d;
  logic [cfsw_pkg::NEXT_LED_W-1:0] next_led_q, next_led_d;
  logic [1:0] next_chan_q, next_chan_d;
  logic [7:0] last_byte_q, last_byte_d;

  logic                            wr_ok;
  logic [cfsw_pkg::STORE_IDX_W-1:0] wr_idx, rd_idx;
  logic [POS_W-1:0]                rd_pos;
  logic                            more_bytes;

  // led * 3 + channel
  assign wr_idx = cfsw_pkg::STORE_IDX_W'({item_i.led_index, 1'b0})
                + cfsw_pkg::STORE_IDX_W'(item_i.led_index)
                + cfsw_pkg::STORE_IDX_W'(item_i.channel);
  assign wr_ok  = (item_i.mode == cfsw_pkg::MODE_WRITE)
               && ({1'b0, item_i.led_index} < 4'(cfsw_pkg::LED_TOTAL))
               && (item_i.channel < 2'(cfsw_pkg::CHANNELS));

  assign rd_pos = POS_W'({next_led_q, 1'b0}) + POS_W'(next_led_q) + POS_W'(next_chan_q);
  assign rd_idx = rd_pos[cfsw_pkg::STORE_IDX_W-1:0];
  assign more_bytes = (next_led_q < cfsw_pkg::NEXT_LED_W'(cfsw_pkg::LED_TOTAL))
                   && (next_chan_q < 2'(cfsw_pkg::CHANNELS));

  always_comb begin
    waiting_d   = waiting_q;
    next_led_d  = next_led_q;
    next_chan_d = next_chan_q;
    last_byte_d = last_byte_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_accept_i) begin
      if (item_i.mode == cfsw_pkg::MODE_START ||
          (item_i.mode == cfsw_pkg::MODE_REPLY && waiting_q &&
           item_i.data_byte != ack_code_q && item_i.data_byte != nak_code_q)) begin
        // open or restart the frame
        waiting_d        = 1'b1;
        next_led_d       = '0;
        next_chan_d      = '0;
        last_byte_d      = start_code_q;
        res_valid_o      = 1'b1;
        res_o.tx_valid   = 1'b1;
        res_o.tx_byte    = start_code_q;
      end else if (item_i.mode == cfsw_pkg::MODE_REPLY && waiting_q) begin
        res_valid_o = 1'b1;
        if (item_i.data_byte == ack_code_q) begin
          if (more_bytes) begin
            last_byte_d    = store_q[rd_idx];
            res_o.tx_valid = 1'b1;
            res_o.tx_byte  = store_q[rd_idx];
            if (next_chan_q == 2'(cfsw_pkg::CHANNELS - 1)) begin
              next_chan_d = '0;
              next_led_d  = next_led_q + 1'b1;
            end else begin
              next_chan_d = next_chan_q + 1'b1;
            end
          end else begin
            waiting_d        = 1'b0;
            res_o.frame_done = 1'b1;
          end
        end else begin
          // nak: resend
          res_o.tx_valid = 1'b1;
          res_o.tx_byte  = last_byte_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= cfsw_pkg::START_CODE_RST;
      ack_code_q   <= cfsw_pkg::ACK_CODE_RST;
      nak_code_q   <= cfsw_pkg::NAK_CODE_RST;
      waiting_q    <= 1'b0;
      next_led_q   <= '0;
      next_chan_q  <= '0;
      last_byte_q  <= '0;
      for (int i = 0; i < int'(cfsw_pkg::STORE_DEPTH); i++) begin
        store_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cfsw_pkg::CFG_START_CODE: start_code_q <= cfg_data_i;
          cfsw_pkg::CFG_ACK_CODE:   ack_code_q   <= cfg_data_i;
          cfsw_pkg::CFG_NAK_CODE:   nak_code_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (item_accept_i && wr_ok) begin
        store_q[wr_idx] <= item_i.data_byte;
      end
      waiting_q   <= waiting_d;
      next_led_q  <= next_led_d;
      next_chan_q <= next_chan_d;
      last_byte_q <= last_byte_d;
    end
  end

endmodule

FILE: rtl/cfsw_out_queue.sv
// ----------------------------------------------------------------------------
// cfsw_out_queue
// Two-entry result queue between the core and the output channel.
// ----------------------------------------------------------------------------
module cfsw_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cfsw_pkg::out_item_t  push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cfsw_pkg::out_item_t  out_data_o,
  output logic [1:0]           count_o
);

  cfsw_pkg::out_item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/color_frame_stop_and_wait_sender.sv
// ----------------------------------------------------------------------------
// color_frame_stop_and_wait_sender
// Stop-and-wait sender of one frame of RGB LED color bytes.
// ----------------------------------------------------------------------------
// The block takes one input transaction every clock cycle while in_stall_o is
// low: a color write, a frame start or a reply byte from the partner. Each is
// decoded in the cycle it is accepted and its result (if any) is registered
// into a two-entry output queue, so input keeps flowing while a result waits
// downstream; in_stall_o rises only when both queue entries are held. The
// color store (8 LEDs x 3 channels) is cleared by reset and needs no clearing
// pass. Configuration writes take effect at the next edge.
// ----------------------------------------------------------------------------
module color_frame_stop_and_wait_sender (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [cfsw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cfsw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cfsw_pkg::in_item_t                in_data_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cfsw_pkg::out_item_t               out_data_o
);

  logic                in_accept;
  logic                res_valid;
  cfsw_pkg::out_item_t res;
  logic                q_full;
  logic [1:0]          q_count;

  // accept whenever the queue has room; full queue guarantees no overflow
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  cfsw_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .item_accept_i (in_accept),
    .item_i        (in_data_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  cfsw_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .count_o     (q_count)
  );

  // queue never holds more than two results
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count != 2'd3)
    else $error("output queue overflow");

  // a done result carries no byte
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> !out_data_o.tx_valid &&
    out_data_o.tx_byte == 8'd0)
    else $error("frame done result with byte");

  // a start transaction always yields a result next cycle
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.mode == cfsw_pkg::MODE_START |=> out_valid_o)
    else $error("start produced no result");

  // stall only when results are pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("stall without pending result");

endmodule
